### sv/kf3_pkg.sv
// ----------------------------------------------------------------------------
// kf3_pkg
// Shared types, constants and the microcode program of the tilt filter.
// ----------------------------------------------------------------------------
package kf3_pkg;

   localparam int FRAC_BITS_DEF  = 16;
   localparam int WORD_WIDTH_DEF = 32;

   localparam int RAM_AW    = 5;
   localparam int RAM_DEPTH = 32;
   localparam int N_STATE   = 12;   // x0..x2, p0..p8
   localparam int PC_W      = 7;

   localparam logic [PC_W-1:0] PC_END = 7'd97;

   // configuration register indexes
   localparam logic [2:0] CSR_SAMPLE_TIME = 3'd0;
   localparam logic [2:0] CSR_Q_ANGLE     = 3'd1;
   localparam logic [2:0] CSR_Q_RATE      = 3'd2;
   localparam logic [2:0] CSR_Q_BIAS      = 3'd3;
   localparam logic [2:0] CSR_R_ANGLE     = 3'd4;
   localparam logic [2:0] CSR_R_RATE      = 3'd5;

   // operand codes: bit 5 clear selects a RAM word, set selects a special source
   localparam logic [5:0] O_X0   = 6'd0;
   localparam logic [5:0] O_X1   = 6'd1;
   localparam logic [5:0] O_X2   = 6'd2;
   localparam logic [5:0] O_P0   = 6'd3;
   localparam logic [5:0] O_P1   = 6'd4;
   localparam logic [5:0] O_P2   = 6'd5;
   localparam logic [5:0] O_P3   = 6'd6;
   localparam logic [5:0] O_P4   = 6'd7;
   localparam logic [5:0] O_P5   = 6'd8;
   localparam logic [5:0] O_P6   = 6'd9;
   localparam logic [5:0] O_P7   = 6'd10;
   localparam logic [5:0] O_P8   = 6'd11;
   localparam logic [5:0] O_TA   = 6'd12;
   localparam logic [5:0] O_Y0   = 6'd13;
   localparam logic [5:0] O_Y1   = 6'd14;
   localparam logic [5:0] O_S00  = 6'd15;
   localparam logic [5:0] O_S11  = 6'd16;
   localparam logic [5:0] O_DET  = 6'd17;
   localparam logic [5:0] O_NUM  = 6'd18;
   localparam logic [5:0] O_K00  = 6'd19;
   localparam logic [5:0] O_K01  = 6'd20;
   localparam logic [5:0] O_K10  = 6'd21;
   localparam logic [5:0] O_K11  = 6'd22;
   localparam logic [5:0] O_K20  = 6'd23;
   localparam logic [5:0] O_K21  = 6'd24;
   localparam logic [5:0] O_OK00 = 6'd25;
   localparam logic [5:0] O_OK11 = 6'd26;
   localparam logic [5:0] O_C0   = 6'd27;
   localparam logic [5:0] O_C1   = 6'd28;
   localparam logic [5:0] O_C2   = 6'd29;
   localparam logic [5:0] SP_IN0  = 6'd32;
   localparam logic [5:0] SP_IN1  = 6'd33;
   localparam logic [5:0] SP_QA   = 6'd34;
   localparam logic [5:0] SP_QR   = 6'd35;
   localparam logic [5:0] SP_QB   = 6'd36;
   localparam logic [5:0] SP_RA   = 6'd37;
   localparam logic [5:0] SP_RR   = 6'd38;
   localparam logic [5:0] SP_ONE  = 6'd39;
   localparam logic [5:0] SP_DT   = 6'd40;
   localparam logic [5:0] SP_ZERO = 6'd41;
   localparam logic [5:0] NO_DST  = 6'd63;

   typedef enum logic [2:0] {
      FN_PASS, FN_MUL, FN_MDT, FN_DIV, FN_OUT
   } fn_type;

   typedef enum logic [1:0] {
      M_LD, M_ADD, M_SUB, M_CHK
   } mode_type;

   typedef struct packed {
      fn_type     fn;
      logic       clr;
      logic       neg;
      logic       chk;
      logic       wr;
      logic [5:0] dst;
      logic [5:0] srca;
      logic [5:0] srcb;
   } instr_type;

   function automatic instr_type mk(fn_type f, mode_type m, logic [5:0] a,
                                    logic [5:0] b, logic [5:0] d);
      instr_type r;
      r.fn   = f;
      r.clr  = (m == M_LD);
      r.neg  = (m == M_SUB) || (m == M_CHK);
      r.chk  = (m == M_CHK);
      r.wr   = (d != NO_DST);
      r.dst  = d;
      r.srca = a;
      r.srcb = b;
      return r;
   endfunction

   // one step of predict / update per entry; accumulator sums then saturates
   function automatic instr_type prog(logic [PC_W-1:0] pc);
      instr_type r;
      case (pc)
         // state prediction
         7'd0:  r = mk(FN_MDT,  M_LD,  O_X1,   SP_DT,   NO_DST);
         7'd1:  r = mk(FN_MDT,  M_SUB, O_X2,   SP_DT,   NO_DST);
         7'd2:  r = mk(FN_PASS, M_ADD, O_X0,   SP_ZERO, O_X0);
         // covariance prediction
         7'd3:  r = mk(FN_MDT,  M_LD,  O_P3,   SP_DT,   NO_DST);
         7'd4:  r = mk(FN_MDT,  M_SUB, O_P6,   SP_DT,   NO_DST);
         7'd5:  r = mk(FN_PASS, M_ADD, O_P0,   SP_ZERO, O_TA);
         7'd6:  r = mk(FN_MDT,  M_LD,  O_P4,   SP_DT,   NO_DST);
         7'd7:  r = mk(FN_MDT,  M_SUB, O_P7,   SP_DT,   NO_DST);
         7'd8:  r = mk(FN_PASS, M_ADD, O_P1,   SP_ZERO, O_P1);
         7'd9:  r = mk(FN_MDT,  M_LD,  O_P5,   SP_DT,   NO_DST);
         7'd10: r = mk(FN_MDT,  M_SUB, O_P8,   SP_DT,   NO_DST);
         7'd11: r = mk(FN_PASS, M_ADD, O_P2,   SP_ZERO, O_P2);
         7'd12: r = mk(FN_MDT,  M_LD,  O_P1,   SP_DT,   NO_DST);
         7'd13: r = mk(FN_MDT,  M_SUB, O_P2,   SP_DT,   NO_DST);
         7'd14: r = mk(FN_PASS, M_ADD, O_TA,   SP_ZERO, NO_DST);
         7'd15: r = mk(FN_PASS, M_ADD, SP_QA,  SP_ZERO, O_P0);
         7'd16: r = mk(FN_MDT,  M_LD,  O_P4,   SP_DT,   NO_DST);
         7'd17: r = mk(FN_MDT,  M_SUB, O_P5,   SP_DT,   NO_DST);
         7'd18: r = mk(FN_PASS, M_ADD, O_P3,   SP_ZERO, O_P3);
         7'd19: r = mk(FN_PASS, M_LD,  O_P4,   SP_ZERO, NO_DST);
         7'd20: r = mk(FN_PASS, M_ADD, SP_QR,  SP_ZERO, O_P4);
         7'd21: r = mk(FN_MDT,  M_LD,  O_P7,   SP_DT,   NO_DST);
         7'd22: r = mk(FN_MDT,  M_SUB, O_P8,   SP_DT,   NO_DST);
         7'd23: r = mk(FN_PASS, M_ADD, O_P6,   SP_ZERO, O_P6);
         7'd24: r = mk(FN_PASS, M_LD,  O_P8,   SP_ZERO, NO_DST);
         7'd25: r = mk(FN_PASS, M_ADD, SP_QB,  SP_ZERO, O_P8);
         // innovation and S
         7'd26: r = mk(FN_PASS, M_LD,  SP_IN0, SP_ZERO, NO_DST);
         7'd27: r = mk(FN_PASS, M_SUB, O_X0,   SP_ZERO, O_Y0);
         7'd28: r = mk(FN_PASS, M_LD,  SP_IN1, SP_ZERO, NO_DST);
         7'd29: r = mk(FN_PASS, M_SUB, O_X1,   SP_ZERO, O_Y1);
         7'd30: r = mk(FN_PASS, M_LD,  O_P0,   SP_ZERO, NO_DST);
         7'd31: r = mk(FN_PASS, M_ADD, SP_RA,  SP_ZERO, O_S00);
         7'd32: r = mk(FN_PASS, M_LD,  O_P4,   SP_ZERO, NO_DST);
         7'd33: r = mk(FN_PASS, M_ADD, SP_RR,  SP_ZERO, O_S11);
         7'd34: r = mk(FN_MUL,  M_LD,  O_S00,  O_S11,   NO_DST);
         7'd35: r = mk(FN_MUL,  M_CHK, O_P1,   O_P3,    O_DET);
         // gains
         7'd36: r = mk(FN_MUL,  M_LD,  O_P0,   O_S11,   NO_DST);
         7'd37: r = mk(FN_MUL,  M_SUB, O_P1,   O_P3,    O_NUM);
         7'd38: r = mk(FN_DIV,  M_LD,  O_NUM,  O_DET,   O_K00);
         7'd39: r = mk(FN_MUL,  M_LD,  O_P1,   O_S00,   NO_DST);
         7'd40: r = mk(FN_MUL,  M_SUB, O_P0,   O_P1,    O_NUM);
         7'd41: r = mk(FN_DIV,  M_LD,  O_NUM,  O_DET,   O_K01);
         7'd42: r = mk(FN_MUL,  M_LD,  O_P3,   O_S11,   NO_DST);
         7'd43: r = mk(FN_MUL,  M_SUB, O_P4,   O_P3,    O_NUM);
         7'd44: r = mk(FN_DIV,  M_LD,  O_NUM,  O_DET,   O_K10);
         7'd45: r = mk(FN_MUL,  M_LD,  O_P4,   O_S00,   NO_DST);
         7'd46: r = mk(FN_MUL,  M_SUB, O_P3,   O_P1,    O_NUM);
         7'd47: r = mk(FN_DIV,  M_LD,  O_NUM,  O_DET,   O_K11);
         7'd48: r = mk(FN_MUL,  M_LD,  O_P6,   O_S11,   NO_DST);
         7'd49: r = mk(FN_MUL,  M_SUB, O_P7,   O_P3,    O_NUM);
         7'd50: r = mk(FN_DIV,  M_LD,  O_NUM,  O_DET,   O_K20);
         7'd51: r = mk(FN_MUL,  M_LD,  O_P7,   O_S00,   NO_DST);
         7'd52: r = mk(FN_MUL,  M_SUB, O_P6,   O_P1,    O_NUM);
         7'd53: r = mk(FN_DIV,  M_LD,  O_NUM,  O_DET,   O_K21);
         // estimate update
         7'd54: r = mk(FN_PASS, M_LD,  O_X0,   SP_ZERO, NO_DST);
         7'd55: r = mk(FN_MUL,  M_ADD, O_K00,  O_Y0,    NO_DST);
         7'd56: r = mk(FN_MUL,  M_ADD, O_K01,  O_Y1,    O_X0);
         7'd57: r = mk(FN_PASS, M_LD,  O_X1,   SP_ZERO, NO_DST);
         7'd58: r = mk(FN_MUL,  M_ADD, O_K10,  O_Y0,    NO_DST);
         7'd59: r = mk(FN_MUL,  M_ADD, O_K11,  O_Y1,    O_X1);
         7'd60: r = mk(FN_PASS, M_LD,  O_X2,   SP_ZERO, NO_DST);
         7'd61: r = mk(FN_MUL,  M_ADD, O_K20,  O_Y0,    NO_DST);
         7'd62: r = mk(FN_MUL,  M_ADD, O_K21,  O_Y1,    O_X2);
         7'd63: r = mk(FN_PASS, M_LD,  SP_ONE, SP_ZERO, NO_DST);
         7'd64: r = mk(FN_PASS, M_SUB, O_K00,  SP_ZERO, O_OK00);
         7'd65: r = mk(FN_PASS, M_LD,  SP_ONE, SP_ZERO, NO_DST);
         7'd66: r = mk(FN_PASS, M_SUB, O_K11,  SP_ZERO, O_OK11);
         // covariance update, column 0
         7'd67: r = mk(FN_MUL,  M_LD,  O_P0,   O_OK00,  NO_DST);
         7'd68: r = mk(FN_MUL,  M_SUB, O_P3,   O_K01,   O_C0);
         7'd69: r = mk(FN_MUL,  M_LD,  O_P3,   O_OK11,  NO_DST);
         7'd70: r = mk(FN_MUL,  M_SUB, O_P0,   O_K10,   O_C1);
         7'd71: r = mk(FN_PASS, M_LD,  O_P6,   SP_ZERO, NO_DST);
         7'd72: r = mk(FN_MUL,  M_SUB, O_P3,   O_K21,   NO_DST);
         7'd73: r = mk(FN_MUL,  M_SUB, O_P0,   O_K20,   O_C2);
         7'd74: r = mk(FN_PASS, M_LD,  O_C0,   SP_ZERO, O_P0);
         7'd75: r = mk(FN_PASS, M_LD,  O_C1,   SP_ZERO, O_P3);
         7'd76: r = mk(FN_PASS, M_LD,  O_C2,   SP_ZERO, O_P6);
         // column 1
         7'd77: r = mk(FN_MUL,  M_LD,  O_P1,   O_OK00,  NO_DST);
         7'd78: r = mk(FN_MUL,  M_SUB, O_P4,   O_K01,   O_C0);
         7'd79: r = mk(FN_MUL,  M_LD,  O_P4,   O_OK11,  NO_DST);
         7'd80: r = mk(FN_MUL,  M_SUB, O_P1,   O_K10,   O_C1);
         7'd81: r = mk(FN_PASS, M_LD,  O_P7,   SP_ZERO, NO_DST);
         7'd82: r = mk(FN_MUL,  M_SUB, O_P4,   O_K21,   NO_DST);
         7'd83: r = mk(FN_MUL,  M_SUB, O_P1,   O_K20,   O_C2);
         7'd84: r = mk(FN_PASS, M_LD,  O_C0,   SP_ZERO, O_P1);
         7'd85: r = mk(FN_PASS, M_LD,  O_C1,   SP_ZERO, O_P4);
         7'd86: r = mk(FN_PASS, M_LD,  O_C2,   SP_ZERO, O_P7);
         // column 2
         7'd87: r = mk(FN_MUL,  M_LD,  O_P2,   O_OK00,  NO_DST);
         7'd88: r = mk(FN_MUL,  M_SUB, O_P5,   O_K01,   O_C0);
         7'd89: r = mk(FN_MUL,  M_LD,  O_P5,   O_OK11,  NO_DST);
         7'd90: r = mk(FN_MUL,  M_SUB, O_P2,   O_K10,   O_C1);
         7'd91: r = mk(FN_PASS, M_LD,  O_P8,   SP_ZERO, NO_DST);
         7'd92: r = mk(FN_MUL,  M_SUB, O_P5,   O_K21,   NO_DST);
         7'd93: r = mk(FN_MUL,  M_SUB, O_P2,   O_K20,   O_C2);
         7'd94: r = mk(FN_PASS, M_LD,  O_C0,   SP_ZERO, O_P2);
         7'd95: r = mk(FN_PASS, M_LD,  O_C1,   SP_ZERO, O_P5);
         7'd96: r = mk(FN_PASS, M_LD,  O_C2,   SP_ZERO, O_P8);
         default: r = mk(FN_OUT, M_LD, O_X0,   SP_ZERO, NO_DST);
      endcase
      return r;
   endfunction

endpackage

### sv/kalman_tilt_fusion_3state_top.sv
// ----------------------------------------------------------------------------
// kalman_tilt_fusion_3state_top
// Three-state tilt Kalman filter (angle, rate, gyro bias) on a word RAM.
// ----------------------------------------------------------------------------
// Each req word carries an accelerometer angle and a gyro rate; each produces
// one rsp word with the new angle estimate and a fault flag that is set when
// the innovation determinant is not positive (the update is then skipped and
// the predicted angle is reported). Estimate, covariance and scratch values
// live in a 32-word RAM with registered reads; a microcode sequencer
// steps through 98 instructions that read up to two operands, run them
// through one shared multiply/divide unit and accumulate into a wide register
// that is saturated on write-back. The divider, one quotient bit per cycle,
// and the single RAM read port set how long an item takes. A new req word is
// taken once the sequencer is idle, even while the previous rsp word still
// waits. After reset a clearing pass loads the initial state before
// req_tready rises; configuration writes are taken at any time and should
// only be done while the block is idle.
// ----------------------------------------------------------------------------
module kalman_tilt_fusion_3state_top
   import kf3_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [24:0] acc_angle, [52:25] gyro_rate, [55:53] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,
   // rsp_tdata: [31:0] tilt_angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // rsp_tuser: [0] gain_fault
   output logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int W  = WORD_WIDTH;
   localparam int AW = W + 3;   // room for four saturated terms
   localparam logic signed [63:0] WMAX = (64'sd1 <<< (W - 1)) - 64'sd1;
   localparam logic signed [63:0] WMIN = -(64'sd1 <<< (W - 1));

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_RA, ST_RB, ST_OPB, ST_ALU, ST_WB, ST_OUT
   } seq_state_type;

   function automatic logic signed [W-1:0] sat_w(logic signed [63:0] v);
      logic signed [63:0] c;
      c = (v > WMAX) ? WMAX : ((v < WMIN) ? WMIN : v);
      return c[W-1:0];
   endfunction

   function automatic logic [31:0] sat32(logic signed [63:0] v);
      logic signed [63:0] c;
      c = (v > 64'sd2147483647) ? 64'sd2147483647 :
          ((v < -64'sd2147483648) ? -64'sd2147483648 : v);
      return c[31:0];
   endfunction

   // configuration
   logic [15:0] st_ff;
   logic [30:0] qa_ff, qr_ff, qb_ff, ra_ff, rr_ff;

   // sequencer
   seq_state_type        state_ff;
   logic [PC_W-1:0]      pc_ff;
   logic [3:0]           init_ff;
   logic signed [24:0]   in0_ff;
   logic signed [27:0]   in1_ff;
   logic signed [W-1:0]  a_ff, b_ff;
   logic signed [AW-1:0] acc_ff;
   logic                 fault_ff, start_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          rsp_data_ff;
   logic                 rsp_fault_ff;

   instr_type            ins;
   logic [5:0]           sel;
   logic signed [W-1:0]  rd_data, opnd, v, acc_sat, init_val;
   logic signed [AW-1:0] acc_base, acc_in;
   logic                 alu_done;
   logic signed [W-1:0]  alu_res;
   logic                 ram_we;
   logic [RAM_AW-1:0]    ram_waddr, ram_raddr;
   logic [W-1:0]         ram_wdata;
   logic                 rsp_free, is_alu;

   assign ins       = prog(pc_ff);
   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign is_alu    = (ins.fn == FN_MUL) || (ins.fn == FN_MDT) || (ins.fn == FN_DIV);

   // operand fetch: RAM word or special source
   always_comb begin
      sel = (state_ff == ST_RB) ? ins.srca : ins.srcb;
      if (!sel[5]) begin
         opnd = rd_data;
      end else begin
         case (sel)
            SP_IN0:  opnd = sat_w(64'(in0_ff));
            SP_IN1:  opnd = sat_w(64'(in1_ff));
            SP_QA:   opnd = sat_w({33'd0, qa_ff});
            SP_QR:   opnd = sat_w({33'd0, qr_ff});
            SP_QB:   opnd = sat_w({33'd0, qb_ff});
            SP_RA:   opnd = sat_w({33'd0, ra_ff});
            SP_RR:   opnd = sat_w({33'd0, rr_ff});
            SP_ONE:  opnd = sat_w(64'sd1 <<< FRAC_BITS);
            SP_DT:   opnd = sat_w({48'd0, st_ff});
            default: opnd = '0;
         endcase
      end
   end

   // accumulate: exact sum, saturated only on write-back
   always_comb begin
      v        = (ins.fn == FN_PASS) ? a_ff : alu_res;
      acc_base = ins.clr ? '0 : acc_ff;
      acc_in   = ins.neg ? (acc_base - AW'(v)) : (acc_base + AW'(v));
      acc_sat  = sat_w(64'(acc_in));
   end

   // reset image: diagonal of P at 1000, the other state words zero
   assign init_val = ((init_ff == O_P0[3:0]) || (init_ff == O_P4[3:0]) ||
                      (init_ff == O_P8[3:0])) ? sat_w(64'sd1000 <<< FRAC_BITS) : '0;

   // address is presented in the cycle before its operand: srca in RA, srcb after
   always_comb begin
      ram_raddr = (state_ff == ST_RA) ? ins.srca[RAM_AW-1:0] : ins.srcb[RAM_AW-1:0];
      if (state_ff == ST_INIT) begin
         ram_we    = 1'b1;
         ram_waddr = RAM_AW'(init_ff);
         ram_wdata = init_val;
      end else begin
         ram_we    = (state_ff == ST_WB) && ins.wr;
         ram_waddr = ins.dst[RAM_AW-1:0];
         ram_wdata = acc_sat;
      end
   end

   kf3_ram #(
      .WORD_WIDTH(W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (rd_data)
   );

   kf3_alu #(
      .WORD_WIDTH(W),
      .FRAC_BITS (FRAC_BITS)
   ) u_alu (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .fn    (ins.fn),
      .a     (a_ff),
      .b     (b_ff),
      .done  (alu_done),
      .res   (alu_res)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= 16'd655;
         qa_ff <= 31'd66;
         qr_ff <= 31'd197;
         qb_ff <= 31'd197;
         ra_ff <= 31'd19661;
         rr_ff <= 31'd6554;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SAMPLE_TIME: st_ff <= csr_data[15:0];
            CSR_Q_ANGLE:     qa_ff <= csr_data[30:0];
            CSR_Q_RATE:      qr_ff <= csr_data[30:0];
            CSR_Q_BIAS:      qb_ff <= csr_data[30:0];
            CSR_R_ANGLE:     ra_ff <= csr_data[30:0];
            CSR_R_RATE:      rr_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      start_ff <= 1'b0;
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         pc_ff        <= '0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // ST_OUT loads the next word itself
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_INIT: begin
               init_ff <= init_ff + 4'd1;
               if (init_ff == 4'(N_STATE - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  in0_ff   <= req_tdata[24:0];
                  in1_ff   <= req_tdata[52:25];
                  pc_ff    <= '0;
                  fault_ff <= 1'b0;
                  state_ff <= ST_RA;
               end
            end
            ST_RA: state_ff <= ST_RB;
            ST_RB: begin
               a_ff     <= opnd;
               state_ff <= ST_OPB;
            end
            ST_OPB: begin
               b_ff <= opnd;
               if (ins.fn == FN_OUT) begin
                  state_ff <= ST_OUT;
               end else if (is_alu) begin
                  start_ff <= 1'b1;
                  state_ff <= ST_ALU;
               end else begin
                  state_ff <= ST_WB;
               end
            end
            ST_ALU: begin
               if (alu_done) begin
                  state_ff <= ST_WB;
               end
            end
            ST_WB: begin
               acc_ff   <= acc_in;
               state_ff <= ST_RA;
               // determinant not positive: keep the prediction, flag it
               if (ins.chk && (acc_sat[W-1] || (acc_sat == '0))) begin
                  fault_ff <= 1'b1;
                  pc_ff    <= PC_END;
               end else begin
                  pc_ff <= pc_ff + PC_W'(1);
               end
            end
            ST_OUT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= sat32(64'(a_ff));
                  rsp_fault_ff <= fault_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_fault_ff;

endmodule

### sv/kf3_ram.sv
// ----------------------------------------------------------------------------
// kf3_ram
// State and scratch word RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module kf3_ram
   import kf3_pkg::*;
#(
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  we,
   input  logic [RAM_AW-1:0]     waddr,
   input  logic [WORD_WIDTH-1:0] wdata,
   input  logic [RAM_AW-1:0]     raddr,
   output logic [WORD_WIDTH-1:0] rdata
);

   logic [WORD_WIDTH-1:0] mem [RAM_DEPTH];
   logic [WORD_WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/kf3_alu.sv
// ----------------------------------------------------------------------------
// kf3_alu
// Shared multi-cycle unit: rounded fixed-point multiply (four partial
// products), multiply by dt, and restoring divide for the gains.
// ----------------------------------------------------------------------------
module kf3_alu
   import kf3_pkg::*;
#(
   parameter int WORD_WIDTH = WORD_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  fn_type                       fn,
   input  logic signed [WORD_WIDTH-1:0] a,
   input  logic signed [WORD_WIDTH-1:0] b,
   output logic                         done,
   output logic signed [WORD_WIDTH-1:0] res
);

   localparam int W  = WORD_WIDTH;
   localparam int H  = (W + 1) / 2;
   localparam int PW = 2 * W + 1;
   localparam int N  = W + FRAC_BITS;
   localparam int CW = $clog2(N + 1);

   typedef enum logic [1:0] {AS_IDLE, AS_MUL, AS_DIV, AS_FIN} alu_state_type;

   alu_state_type state_ff;
   logic [1:0]    ph_ff;
   logic [CW-1:0] cnt_ff;
   logic          neg_ff, mdt_ff, div_ff, done_ff;
   logic [W-1:0]  ma_ff, mb_ff;
   logic [PW-1:0] prod_ff;
   logic [W:0]    rem_ff;
   logic [N-1:0]  quo_ff;
   logic signed [W-1:0] res_ff;

   logic [W-1:0]   abs_a, abs_b;
   logic [H-1:0]   mx, my;
   logic [2*H-1:0] pp;
   logic [PW-1:0]  pp_sh, mag;
   logic [W:0]     rem_t;
   logic           ge, rnd;

   function automatic logic [W-1:0] clamp(logic [PW-1:0] m, logic neg);
      logic [PW-1:0] lim;
      logic [W-1:0]  mw;
      lim = neg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
      mw  = (m > lim) ? lim[W-1:0] : m[W-1:0];
      return neg ? (~mw + W'(1)) : mw;
   endfunction

   always_comb begin
      abs_a = a[W-1] ? (~a + W'(1)) : a;
      abs_b = b[W-1] ? (~b + W'(1)) : b;
      mx    = ph_ff[0] ? H'(ma_ff >> H) : ma_ff[H-1:0];
      my    = ph_ff[1] ? H'(mb_ff >> H) : mb_ff[H-1:0];
      pp    = mx * my;
      case (ph_ff)
         2'd0:    pp_sh = PW'(pp);
         2'd3:    pp_sh = PW'(pp) << (2 * H);
         default: pp_sh = PW'(pp) << H;
      endcase
      rem_t = {rem_ff[W-1:0], quo_ff[N-1]};
      ge    = rem_t >= {1'b0, mb_ff};
      rnd   = {rem_ff, 1'b0} >= {2'b00, mb_ff};
      if (div_ff) begin
         mag = PW'(quo_ff) + PW'(rnd);
      end else if (mdt_ff) begin
         mag = (prod_ff + (PW'(1) << 15)) >> 16;
      end else begin
         mag = (prod_ff + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= AS_IDLE;
         ph_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            AS_IDLE: begin
               if (start) begin
                  mdt_ff  <= (fn == FN_MDT);
                  div_ff  <= (fn == FN_DIV);
                  ma_ff   <= abs_a;
                  prod_ff <= '0;
                  ph_ff   <= '0;
                  if (fn == FN_DIV) begin
                     neg_ff   <= a[W-1];
                     mb_ff    <= b;
                     rem_ff   <= '0;
                     quo_ff   <= {abs_a, {FRAC_BITS{1'b0}}};
                     cnt_ff   <= CW'(N);
                     state_ff <= AS_DIV;
                  end else begin
                     neg_ff   <= a[W-1] ^ b[W-1];
                     mb_ff    <= abs_b;
                     state_ff <= AS_MUL;
                  end
               end
            end
            AS_MUL: begin
               prod_ff <= prod_ff + pp_sh;
               ph_ff   <= ph_ff + 2'd1;
               if (ph_ff == 2'd3) begin
                  state_ff <= AS_FIN;
               end
            end
            AS_DIV: begin
               rem_ff <= ge ? (rem_t - {1'b0, mb_ff}) : rem_t;
               quo_ff <= {quo_ff[N-2:0], ge};
               cnt_ff <= cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  state_ff <= AS_FIN;
               end
            end
            AS_FIN: begin
               res_ff   <= clamp(mag, neg_ff);
               done_ff  <= 1'b1;
               state_ff <= AS_IDLE;
            end
            default: state_ff <= AS_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule
